// ----- rtl/irs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the image remap sampler.
// No dependencies.
package irs_pkg;
	localparam int MAX_WIDTH_D  = 256;
	localparam int MAX_HEIGHT_D = 256;
	localparam int FRAC_BITS_D  = 8;
	localparam int COORD_W      = 20;
	localparam int IDX_W        = 16;
	localparam int DIM_W        = 9;
	localparam int PIX_W        = 24;
	localparam int ADDR_W       = 3;
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_INTERP = 3'd2;
	localparam logic [2:0] REG_EDGE   = 3'd3;
	localparam logic [2:0] REG_FILL   = 3'd4;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_REMAP = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  load_index;
		logic [7:0]        load_blue;
		logic [7:0]        load_green;
		logic [7:0]        load_red;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} out_item_t;
endpackage

// ----- rtl/irs_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat.
// Depends on nothing but the payload type given as parameter.
interface irs_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/irs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts beats, splits coordinates, computes four taps, passes loads on in order.
// Depends on irs_pkg.
module irs_front #(
	parameter int MAX_WIDTH  = irs_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = irs_pkg::MAX_HEIGHT_D,
	parameter int FRAC_BITS  = irs_pkg::FRAC_BITS_D,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT),
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  irs_pkg::in_item_t        in_data,
	input  logic [irs_pkg::DIM_W-1:0] image_width,
	input  logic [irs_pkg::DIM_W-1:0] image_height,
	input  logic                     interp_mode,
	input  logic                     edge_mode,
	output logic                     q_valid,
	input  logic                     q_ready,
	output logic                     q_load,
	output logic [irs_pkg::PIX_W-1:0] q_wdata,
	output logic [4*AW-1:0]          q_addr,
	output logic [3:0]               q_fill,
	output logic [2*FRAC_BITS-1:0]   q_frac
);
	localparam int CWID = irs_pkg::COORD_W;
	localparam int IW = CWID - FRAC_BITS + 2;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

	logic signed [IW-1:0] xi_s1, yi_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;
	logic v_s1;
	logic ld_s1;
	logic [AW-1:0] wa_s1;
	logic [irs_pkg::PIX_W-1:0] wd_s1;
	logic [13:0] w_ext, h_ext;
	logic signed [IW-1:0] w_s, h_s;
	logic adv1;

	function automatic logic signed [IW-1:0] split(input logic signed [CWID-1:0] v,
		input logic nearest);
		logic signed [CWID:0] t;
		logic signed [IW-1:0] i;
		begin
			if (nearest) begin
				t = $signed({v[CWID-1], v}) + $signed((CWID+1)'(1 << (FRAC_BITS - 1)));
				if (t[CWID])
					i = IW'(-((-t) >>> FRAC_BITS));
				else
					i = IW'(t >>> FRAC_BITS);
			end else begin
				i = IW'(v >>> FRAC_BITS);
			end
			split = i;
		end
	endfunction

	always_comb begin
		w_ext = (image_width == '0) ? 14'd1 :
			((32'(image_width) > MAX_WIDTH) ? 14'(MAX_WIDTH) : 14'(image_width));
		h_ext = (image_height == '0) ? 14'd1 :
			((32'(image_height) > MAX_HEIGHT) ? 14'(MAX_HEIGHT) : 14'(image_height));
		w_s = $signed(IW'(w_ext));
		h_s = $signed(IW'(h_ext));
	end

	assign adv1 = !v_s1 || q_ready;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid && (in_data.kind == irs_pkg::KIND_REMAP ||
				32'(in_data.load_index) < DEPTH);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ld_s1 <= in_data.kind == irs_pkg::KIND_LOAD;
			wa_s1 <= AW'(in_data.load_index);
			wd_s1 <= {in_data.load_blue, in_data.load_green, in_data.load_red};
			xi_s1 <= split(in_data.x_coord, !interp_mode);
			yi_s1 <= split(in_data.y_coord, !interp_mode);
			fx_s1 <= interp_mode ? in_data.x_coord[FRAC_BITS-1:0] : '0;
			fy_s1 <= interp_mode ? in_data.y_coord[FRAC_BITS-1:0] : '0;
		end
	end

	always_comb begin
		logic signed [IW-1:0] c, r;
		logic out_c, out_r;
		logic [CW-1:0] cc;
		logic [RW-1:0] rr;
		for (int k = 0; k < 4; k++) begin
			c = xi_s1 + IW'(k & 1);
			r = yi_s1 + IW'(k >> 1);
			out_c = c < 0 || c >= w_s;
			out_r = r < 0 || r >= h_s;
			q_fill[k] = (out_c || out_r) && !edge_mode;
			cc = (c < 0) ? '0 : ((c >= w_s) ? CW'(w_s - 1) : CW'(c));
			rr = (r < 0) ? '0 : ((r >= h_s) ? RW'(h_s - 1) : RW'(r));
			q_addr[k*AW +: AW] = AW'(32'(rr) * 32'(w_ext) + 32'(cc));
		end
		if (ld_s1)
			q_addr[AW-1:0] = wa_s1;
	end

	assign q_valid = v_s1;
	assign q_load = ld_s1;
	assign q_wdata = wd_s1;
	assign q_frac = {fy_s1, fx_s1};
endmodule

// ----- rtl/irs_back.sv -----
`timescale 1ns / 1ps
// Back end: two-entry queue, image memory banks, fetch and blend pipeline, four-entry output buffer.
// Depends on irs_pkg.
module irs_back #(
	parameter int MAX_WIDTH  = irs_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = irs_pkg::MAX_HEIGHT_D,
	parameter int FRAC_BITS  = irs_pkg::FRAC_BITS_D,
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  logic                      q_load,
	input  logic [irs_pkg::PIX_W-1:0] q_wdata,
	input  logic [4*AW-1:0]           q_addr,
	input  logic [3:0]                q_fill,
	input  logic [2*FRAC_BITS-1:0]    q_frac,
	input  logic [7:0]                fill_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output irs_pkg::out_item_t        out_data
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PW = irs_pkg::PIX_W;
	localparam int EW = 1 + PW + 4 * AW + 4 + 2 * FRAC_BITS;
	localparam int FB = 2 * FRAC_BITS;
	localparam int AB = FB + 4;
	localparam int DB = AB + 4 * AW;
	localparam int SW = 2 * FRAC_BITS + 10;

	logic [EW-1:0] fifo_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wp_q;
	logic [EW-1:0] head;
	logic pop, push;
	logic hd_load;
	logic [PW-1:0] hd_wdata;
	logic [AW-1:0] hd_addr [4];

	logic [PW-1:0] bank0 [DEPTH];
	logic [PW-1:0] bank1 [DEPTH];
	logic [PW-1:0] bank2 [DEPTH];
	logic [PW-1:0] bank3 [DEPTH];

	logic v_s2, v_s3, v_s4;
	logic [PW-1:0] p_s2 [4];
	logic [3:0] fill_s2;
	logic [2*FRAC_BITS-1:0] fr_s2, fr_s3;
	logic [FRAC_BITS+8:0] top_s3 [3], bot_s3 [3];
	logic [7:0] res_s4 [3];
	logic [2:0] ocnt_q;
	irs_pkg::out_item_t obuf_q [4];
	logic [1:0] orp_q, owp_q;
	logic [2:0] pend;
	logic out_hs;

	assign head = fifo_q[rd_q];
	assign hd_load = head[EW-1];
	assign hd_wdata = head[DB +: PW];
	assign hd_addr[0] = head[AB +: AW];
	assign hd_addr[1] = head[AB + AW +: AW];
	assign hd_addr[2] = head[AB + 2*AW +: AW];
	assign hd_addr[3] = head[AB + 3*AW +: AW];

	assign out_hs = out_valid && out_ready;
	assign pend = ocnt_q + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign pop = cnt_q != 2'd0 && (hd_load || pend < 3'd4 || out_hs);
	assign q_ready = cnt_q != 2'd2;
	assign push = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wp_q <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= {q_load, q_wdata, q_addr, q_fill, q_frac};
	end

	always_ff @(posedge clk) begin
		if (pop && hd_load) begin
			bank0[hd_addr[0]] <= hd_wdata;
			bank1[hd_addr[0]] <= hd_wdata;
			bank2[hd_addr[0]] <= hd_wdata;
			bank3[hd_addr[0]] <= hd_wdata;
		end
		p_s2[0] <= bank0[hd_addr[0]];
		p_s2[1] <= bank1[hd_addr[1]];
		p_s2[2] <= bank2[hd_addr[2]];
		p_s2[3] <= bank3[hd_addr[3]];
		fill_s2 <= head[FB +: 4];
		fr_s2 <= head[2*FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= pop && !hd_load;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [7:0] a, b, c, d;
		logic [FRAC_BITS:0] fx, nfx;
		logic [FRAC_BITS:0] fy, nfy;
		logic [SW-1:0] s;
		fx = {1'b0, fr_s2[FRAC_BITS-1:0]};
		nfx = (FRAC_BITS+1)'(1 << FRAC_BITS) - fx;
		for (int k = 0; k < 3; k++) begin
			a = fill_s2[0] ? fill_value : p_s2[0][(2-k)*8 +: 8];
			b = fill_s2[1] ? fill_value : p_s2[1][(2-k)*8 +: 8];
			c = fill_s2[2] ? fill_value : p_s2[2][(2-k)*8 +: 8];
			d = fill_s2[3] ? fill_value : p_s2[3][(2-k)*8 +: 8];
			top_s3[k] <= (FRAC_BITS+9)'(a * nfx + b * fx);
			bot_s3[k] <= (FRAC_BITS+9)'(c * nfx + d * fx);
		end
		fr_s3 <= fr_s2;
		fy = {1'b0, fr_s3[2*FRAC_BITS-1:FRAC_BITS]};
		nfy = (FRAC_BITS+1)'(1 << FRAC_BITS) - fy;
		for (int k = 0; k < 3; k++) begin
			s = SW'(top_s3[k] * nfy) + SW'(bot_s3[k] * fy) + SW'(1 << (2*FRAC_BITS-1));
			res_s4[k] <= (s[SW-1:2*FRAC_BITS] > 255) ? 8'hFF : s[2*FRAC_BITS +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
			orp_q <= '0;
			owp_q <= '0;
		end else begin
			if (v_s4) owp_q <= owp_q + 2'd1;
			if (out_hs) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(v_s4) - 3'(out_hs);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) obuf_q[owp_q] <= '{res_s4[0], res_s4[1], res_s4[2]};
	end

	assign out_valid = ocnt_q != 3'd0;
	assign out_data = obuf_q[orp_q];
endmodule

// ----- rtl/image_remap_sampler_core.sv -----
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | kind, load_index, load_blue/green/red, x_coord, y_coord
// out     | out | out_blue, out_green, out_red
// cfg     | in  | APB write/read of five registers
// One beat per cycle unless the output stalls; a remap passes queue, fetch and blend.
// Loads pass through the queue, so they reach memory in order with remaps.
// The four taps are read in parallel from four image memory copies.
// Reset clears control only; image memory is undefined until loaded.
// Either side may stall; the queue and four-entry output buffer absorb it.
module image_remap_sampler_core #(
	parameter int MAX_WIDTH  = irs_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = irs_pkg::MAX_HEIGHT_D,
	parameter int FRAC_BITS  = irs_pkg::FRAC_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	irs_stream_if.sink  in,
	irs_stream_if.source out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [irs_pkg::ADDR_W+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	logic [irs_pkg::DIM_W-1:0] width_q, height_q;
	logic interp_q, edge_q;
	logic [7:0] fill_q;
	logic q_valid, q_ready, q_load;
	logic [irs_pkg::PIX_W-1:0] q_wdata;
	logic [4*AW-1:0] q_addr;
	logic [3:0] q_fill;
	logic [2*FRAC_BITS-1:0] q_frac;
	logic [irs_pkg::ADDR_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[irs_pkg::ADDR_W+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			interp_q <= 1'b0;
			edge_q <= 1'b0;
			fill_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				irs_pkg::REG_WIDTH:  width_q <= pwdata[8:0];
				irs_pkg::REG_HEIGHT: height_q <= pwdata[8:0];
				irs_pkg::REG_INTERP: interp_q <= pwdata[0];
				irs_pkg::REG_EDGE:   edge_q <= pwdata[0];
				irs_pkg::REG_FILL:   fill_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			irs_pkg::REG_WIDTH:  prdata = 32'(width_q);
			irs_pkg::REG_HEIGHT: prdata = 32'(height_q);
			irs_pkg::REG_INTERP: prdata = 32'(interp_q);
			irs_pkg::REG_EDGE:   prdata = 32'(edge_q);
			irs_pkg::REG_FILL:   prdata = 32'(fill_q);
			default:             prdata = '0;
		endcase
	end

	irs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
		.image_width(width_q), .image_height(height_q),
		.interp_mode(interp_q), .edge_mode(edge_q),
		.q_valid, .q_ready, .q_load, .q_wdata, .q_addr, .q_fill, .q_frac
	);

	irs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_load, .q_wdata, .q_addr, .q_fill, .q_frac,
		.fill_value(fill_q),
		.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
	);
endmodule

// ----- rtl/irs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the sampler core, bound to the top level.
// Depends on irs_pkg.
module irs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input irs_pkg::out_item_t out_data,
	input logic pready
);
	a_pready: assert property (@(posedge clk) pready) else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out valid dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("out data changed");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid) else $error("in valid dropped");
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out valid in reset");
endmodule

bind image_remap_sampler_core irs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data), .pready(pready)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the image remap sampler: loads source images, remaps
// coordinates in nearest and bilinear modes under both border modes.
// Depends on irs_pkg, irs_stream_if and image_remap_sampler_core.
module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [irs_pkg::ADDR_W+1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	irs_stream_if #(.payload_t(irs_pkg::in_item_t)) in_ch (clk);
	irs_stream_if #(.payload_t(irs_pkg::out_item_t)) out_ch (clk);

	image_remap_sampler_core dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [23:0] image_mem [0:65535];
	int img_w = 256, img_h = 256;
	bit bilinear = 0, replicate = 0;
	logic [7:0] fill = 0;
	int cur_w = 1, cur_h = 1;
	irs_pkg::out_item_t pixel_queue[$];
	int send_idle = 0, recv_idle = 0;
	int errors = 0, remaps = 0, loads = 0;
	int quiet = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	function automatic int eff(int v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	function automatic logic [23:0] tap(int col, int row);
		int w, h;
		w = eff(img_w);
		h = eff(img_h);
		if (col < 0 || col >= w || row < 0 || row >= h) begin
			if (!replicate) return {fill, fill, fill};
			if (col < 0) col = 0;
			if (col >= w) col = w - 1;
			if (row < 0) row = 0;
			if (row >= h) row = h - 1;
		end
		return image_mem[row * w + col];
	endfunction

	function automatic int floor_fx(int v);
		return v >>> 8;
	endfunction

	function automatic int trunc_fx(int v);
		if (v >= 0) return v >>> 8;
		return -((-v) >>> 8);
	endfunction

	function automatic irs_pkg::out_item_t sample_pixel(int x, int y);
		irs_pkg::out_item_t r;
		logic [23:0] p00, p01, p10, p11, pr;
		int x0, y0;
		longint fx, fy, top, bot, s, v;
		if (!bilinear) begin
			pr = tap(trunc_fx(x + 128), trunc_fx(y + 128));
		end else begin
			x0 = floor_fx(x);
			y0 = floor_fx(y);
			fx = x - x0 * 256;
			fy = y - y0 * 256;
			p00 = tap(x0, y0);
			p01 = tap(x0 + 1, y0);
			p10 = tap(x0, y0 + 1);
			p11 = tap(x0 + 1, y0 + 1);
			for (int k = 0; k < 3; k++) begin
				top = p00[k*8 +: 8] * (256 - fx) + p01[k*8 +: 8] * fx;
				bot = p10[k*8 +: 8] * (256 - fx) + p11[k*8 +: 8] * fx;
				s = top * (256 - fy) + bot * fy;
				v = (s + 32768) >>> 16;
				pr[k*8 +: 8] = v > 255 ? 8'd255 : v[7:0];
			end
		end
		r.out_blue = pr[23:16];
		r.out_green = pr[15:8];
		r.out_red = pr[7:0];
		return r;
	endfunction

	task automatic send_beat(irs_pkg::in_item_t it);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (it.kind == irs_pkg::KIND_LOAD) begin
			image_mem[it.load_index] = {it.load_blue, it.load_green, it.load_red};
			loads++;
		end else begin
			pixel_queue.push_back(sample_pixel(int'(it.x_coord), int'(it.y_coord)));
			remaps++;
		end
	endtask

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle);
		if (out_ch.valid && out_ch.ready) begin
			if (pixel_queue.size() == 0) begin
				$error("pixel with none expected");
				errors++;
			end else begin
				irs_pkg::out_item_t e;
				e = pixel_queue.pop_front();
				if (e.out_blue !== out_ch.data.out_blue) begin
					$error("out_blue exp %0d got %0d", e.out_blue, out_ch.data.out_blue);
					errors++;
				end
				if (e.out_green !== out_ch.data.out_green) begin
					$error("out_green exp %0d got %0d", e.out_green, out_ch.data.out_green);
					errors++;
				end
				if (e.out_red !== out_ch.data.out_red) begin
					$error("out_red exp %0d got %0d", e.out_red, out_ch.data.out_red);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [irs_pkg::ADDR_W-1:0] idx, int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic setup(int w, int h, bit bl, bit rep, int fv);
		drain();
		write_reg(irs_pkg::REG_WIDTH, w);
		write_reg(irs_pkg::REG_HEIGHT, h);
		write_reg(irs_pkg::REG_INTERP, int'(bl));
		write_reg(irs_pkg::REG_EDGE, int'(rep));
		write_reg(irs_pkg::REG_FILL, fv);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		img_w = w; img_h = h; bilinear = bl; replicate = rep; fill = 8'(fv);
	endtask

	task automatic load_pixel(int idx, logic [23:0] p);
		irs_pkg::in_item_t it;
		it = '0;
		it.kind = irs_pkg::KIND_LOAD;
		it.load_index = irs_pkg::IDX_W'(idx);
		{it.load_blue, it.load_green, it.load_red} = p;
		it.x_coord = irs_pkg::COORD_W'($urandom);
		it.y_coord = irs_pkg::COORD_W'($urandom);
		send_beat(it);
	endtask

	// fill the whole active image so every tap reads written data
	task automatic load_image(int w, int h);
		for (int i = 0; i < eff(w) * eff(h); i++) load_pixel(i, 24'($urandom));
		cur_w = eff(w);
		cur_h = eff(h);
	endtask

	task automatic remap(int x, int y);
		irs_pkg::in_item_t it;
		it = '0;
		it.kind = irs_pkg::KIND_REMAP;
		it.load_index = irs_pkg::IDX_W'($urandom);
		{it.load_blue, it.load_green, it.load_red} = 24'($urandom);
		it.x_coord = irs_pkg::COORD_W'(x);
		it.y_coord = irs_pkg::COORD_W'(y);
		send_beat(it);
	endtask

	task automatic random_remap();
		int x, y;
		if ($urandom_range(9) == 0) begin
			x = $signed(20'($urandom));
			y = $signed(20'($urandom));
		end else begin
			x = $urandom_range(cur_w * 256 + 1024) - 768;
			y = $urandom_range(cur_h * 256 + 1024) - 768;
		end
		remap(x, y);
	endtask

	task automatic test_directed();
		setup(4, 3, 0, 0, 8'hA5);
		load_image(4, 3);
		remap(0, 0);
		remap(-128, -129);
		remap(-383, 0);
		remap(3 * 256 + 127, 2 * 256 + 127);
		remap(3 * 256 + 128, 0);
		remap(-524288, 524287);
		remap(524287, -524288);
		setup(4, 3, 1, 0, 8'hFF);
		remap(128, 128);
		remap(-1, -1);
		remap(2 * 256 + 255, 1 * 256 + 1);
		remap(3 * 256, 2 * 256);
		setup(4, 3, 1, 1, 0);
		remap(-300, -700);
		remap(5000, 4000);
		remap(3 * 256 + 200, 100);
		// stray loads past the active image are harmless
		load_pixel(65535, 24'hFFFFFF);
		load_pixel(32768, 24'h000000);
		remap(256, 256);
	endtask

	task automatic test_width_height_edges();
		setup(0, 0, 0, 1, 0);
		load_image(1, 1);
		repeat (6) random_remap();
		setup(1, 256, 1, 1, 0);
		load_image(1, 256);
		repeat (20) random_remap();
		// hold the sender until all results are back
		drain();
		setup(511, 1, 1, 0, 255);
		load_image(256, 1);
		repeat (20) random_remap();
	endtask

	task automatic test_random(int n);
		int w, h;
		while (n > 0) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 24);
			setup(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
				int'($urandom_range(255)));
			load_image(w, h);
			n -= w * h;
			for (int i = 0; i < 60; i++) begin
				random_remap();
				if ($urandom_range(15) == 0)
					load_pixel(int'($urandom_range(cur_w * cur_h - 1)), 24'($urandom));
			end
			n -= 60;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 16; recv_idle = 61;
		test_directed();
		test_width_height_edges();
		test_random(250);
		send_idle = 61; recv_idle = 16;
		test_random(250);
		send_idle = 0; recv_idle = 0;
		setup(256, 256, 1, 1, 0);
		load_image(16, 16);
		test_random(150);
		drain();
		$display("covered %0d loads and %0d remaps", loads, remaps);
		$display("nearest/bilinear, fill/replicate, widths and heights 1..256");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
